FILE: sv/contiguous_page_allocator_top_assert.svh
// Assertion macros for the contiguous page allocator.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define CPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/cpa_pkg.sv
// Package with constants and types of the contiguous page allocator.
package cpa_pkg;
  localparam int NumPages = 1024;
  localparam int WordBits = 32;
  localparam int NumWords = NumPages / WordBits;
  localparam int PageW = $clog2(NumPages);
  localparam int WordW = $clog2(NumWords);
  localparam int BitW = $clog2(WordBits);
  localparam int CntW = 11;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NORUN   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic CFG_MANAGED  = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef struct packed {
    logic [CntW-1:0] managed;
    logic [CntW-1:0] reserved;
  } cfg_t;
endpackage

FILE: sv/cpa_len_ram.sv
// Block length memory with one write port and one registered read port.
module cpa_len_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [cpa_pkg::PageW-1:0] waddr,
  input  logic [cpa_pkg::CntW-1:0]  wdata,
  input  logic [cpa_pkg::PageW-1:0] raddr,
  output logic [cpa_pkg::CntW-1:0]  rdata
);
  import cpa_pkg::*;

  logic [CntW-1:0] mem [NumPages];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/contiguous_page_allocator_top.sv
// Top level of the first-fit contiguous page allocator.
// An allocate scans the bitmap word by word from page 0 and then marks the pages of the run
// it found; a release reads the block length and then clears the pages of the block.
// A zero-count allocate is answered without a scan.
// One request at a time; the next is taken the cycle after the response handshake.
// Reset: config returns to its reset values, then the bitmap is cleared word by word and
// then the length memory entry by entry; no request is taken meanwhile.
module contiguous_page_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // page_count[10:0], page_addr[20:11], zero pad
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0], start_page[11:2], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import cpa_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_SREAD  = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_MREAD  = 9'b000010000,
    S_MARK   = 9'b000100000,
    S_RLEN   = 9'b001000000,
    S_RLWAIT = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  cfg_t   cfg;

  // Bitmap memory: one word per 32 pages.
  logic [WordBits-1:0] bmap [NumWords];
  logic [WordBits-1:0] bm_rdata;
  logic [WordW-1:0]    bm_raddr;
  logic                bm_we;
  logic [WordW-1:0]    bm_waddr;
  logic [WordBits-1:0] bm_wdata;

  // Request and working registers.
  logic            func;
  logic [CntW-1:0] count;
  logic [PageW-1:0] addr;
  logic [CntW-1:0] lim;
  logic [CntW:0]   pos;      // page number of the word under work
  logic [CntW-1:0] run;
  logic [CntW-1:0] start;
  logic [CntW:0]   mark_end; // one past last page to change
  logic            mark_val;
  logic            clr_len;
  logic [PageW:0]  clr_cnt;
  status_t         status;
  logic [PageW-1:0] out_start;

  // Length memory signals.
  logic             len_we;
  logic [PageW-1:0] len_waddr;
  logic [CntW-1:0]  len_wdata;
  logic [CntW-1:0]  len_rdata;

  cpa_len_ram u_len (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .raddr(addr),
    .rdata(len_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {4'd0, out_start, status};
  assign lim = (cfg.managed > CntW'(NumPages)) ? CntW'(NumPages) : cfg.managed;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bmap[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bmap[bm_raddr];
  end
  assign bm_raddr = pos[BitW +: WordBits == 32 ? WordW : WordW];

  // Scan of one bitmap word: the run ending at each page is formed in parallel from the
  // nearest unavailable page below it in the word, and the lowest page that completes
  // the requested run is picked.
  logic [CntW-1:0] sc_run;
  logic            sc_hit;
  logic [CntW:0]   sc_end;
  logic            sc_stop;
  always_comb begin
    logic [WordBits-1:0] fv;
    logic [WordBits-1:0] inr;
    logic [CntW:0]       p;
    logic [CntW:0]       rb;
    logic                seen;
    logic [BitW-1:0]     lnf;
    sc_run  = run;
    sc_hit  = 1'b0;
    sc_end  = '0;
    sc_stop = 1'b0;
    // Pages inside the managed range, and those of them that are free.
    for (int b = 0; b < WordBits; b++) begin
      p      = pos + (CntW+1)'(b);
      inr[b] = (p < {1'b0, lim});
      fv[b]  = inr[b] && (p >= {1'b0, cfg.reserved}) && !bm_rdata[b];
    end
    // Downward so that the lowest hit is the one kept.
    for (int b = WordBits - 1; b >= 0; b--) begin
      seen = 1'b0;
      lnf  = '0;
      for (int k = 0; k <= b; k++) begin
        if (!fv[k]) begin
          seen = 1'b1;
          lnf  = BitW'(k);
        end
      end
      rb = seen ? (CntW+1)'(b) - (CntW+1)'(lnf) : {1'b0, run} + (CntW+1)'(b + 1);
      if (b == WordBits - 1) begin
        sc_run = rb[CntW-1:0];
      end
      if (inr[b] && rb >= {1'b0, count}) begin
        sc_hit = 1'b1;
        sc_end = pos + (CntW+1)'(b + 1);
      end
    end
    sc_stop = !sc_hit && !inr[WordBits-1];
  end

  // Mark pages [start, mark_end) inside the word at pos with mark_val.
  logic [WordBits-1:0] mk_word;
  always_comb begin
    logic [CntW:0] p;
    mk_word = bm_rdata;
    for (int b = 0; b < WordBits; b++) begin
      p = pos + (CntW+1)'(b);
      if (p >= {1'b0, start} && p < mark_end) begin
        mk_word[b] = mark_val;
      end
    end
  end

  logic [CntW:0] next_pos;
  assign next_pos = pos + (CntW+1)'(WordBits);

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = pos[BitW +: WordW];
    bm_wdata  = mk_word;
    len_we    = 1'b0;
    len_waddr = addr;
    len_wdata = '0;
    if (state == S_CLEAR) begin
      if (!clr_len) begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt[WordW-1:0];
        bm_wdata = '0;
      end else begin
        len_we    = 1'b1;
        len_waddr = clr_cnt[PageW-1:0];
      end
    end else if (state == S_MARK) begin
      bm_we = 1'b1;
    end else if (state == S_SCAN && sc_hit && func == FUNC_ALLOC) begin
      len_we    = 1'b1;
      len_waddr = PageW'(sc_end - (CntW+1)'(count));
      len_wdata = count;
    end else if (state == S_RLWAIT && {1'b0, addr} < lim && len_rdata != '0) begin
      len_we = 1'b1;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_len <= 1'b0;
      clr_cnt <= '0;
      cfg.managed  <= CntW'(1024);
      cfg.reserved <= CntW'(1);
      pos     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MANAGED) begin
          cfg.managed <= cfg_data;
        end else begin
          cfg.reserved <= cfg_data;
        end
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (!clr_len && clr_cnt == (PageW+1)'(NumWords - 1)) begin
            clr_len <= 1'b1;
            clr_cnt <= '0;
          end else if (clr_len && clr_cnt == (PageW+1)'(NumPages - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func  <= s_axis_tuser;
            count <= s_axis_tdata[10:0];
            addr  <= s_axis_tdata[20:11];
            run   <= '0;
            pos   <= '0;
            out_start <= '0;
            if (s_axis_tuser == FUNC_ALLOC) begin
              if (s_axis_tdata[10:0] == '0) begin
                status <= ST_INVALID;
                state  <= S_OUT;
              end else begin
                state <= S_SREAD;
              end
            end else begin
              state <= S_RLEN;
            end
          end
        end
        S_SREAD: begin
          if (pos >= {1'b0, lim}) begin
            status <= ST_NORUN;
            state  <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sc_hit) begin
            start     <= CntW'(sc_end - (CntW+1)'(count));
            mark_end  <= sc_end;
            mark_val  <= 1'b1;
            out_start <= PageW'(sc_end - (CntW+1)'(count));
            status    <= ST_OK;
            pos       <= (sc_end - (CntW+1)'(count)) & ~(CntW+1)'(WordBits - 1);
            state     <= S_MREAD;
          end else if (sc_stop) begin
            status <= ST_NORUN;
            state  <= S_OUT;
          end else begin
            run   <= sc_run;
            pos   <= next_pos;
            state <= S_SREAD;
          end
        end
        S_MREAD: begin
          state <= S_MARK;
        end
        S_MARK: begin
          if (next_pos >= mark_end || next_pos >= (CntW+1)'(NumPages)) begin
            state <= S_OUT;
          end else begin
            pos   <= next_pos;
            state <= S_MREAD;
          end
        end
        S_RLEN: begin
          state <= S_RLWAIT;
        end
        S_RLWAIT: begin
          if ({1'b0, addr} < lim && len_rdata != '0) begin
            start    <= {1'b0, addr};
            mark_end <= {1'b0, addr} + {1'b0, len_rdata};
            mark_val <= 1'b0;
            status   <= ST_OK;
            pos      <= {1'b0, addr} & ~(CntW+1)'(WordBits - 1);
            state    <= S_MREAD;
          end else begin
            status <= ST_INVALID;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`include "contiguous_page_allocator_top_assert.svh"
  `CPA_ASSERT_IMPL(a_one_hot, 1'b1, $onehot(state), "state not one-hot")
  `CPA_ASSERT_IMPL(a_no_in_busy, state != S_IDLE, !s_axis_tready, "ready while busy")
  `CPA_ASSERT_IMPL(a_ok_start, m_axis_tvalid && status != ST_OK, out_start == '0,
                   "nonzero start on failure")
  `CPA_ASSERT_NEXT(a_mark_wr, state == S_MREAD, state == S_MARK, "mark read not followed by write")
endmodule

FILE: verif/cpa_checker.sv
// Checker that predicts allocator responses and compares them with the block's outputs.
module cpa_checker
  import cpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t   status;
    logic [PageW-1:0] start_page;
  } alloc_resp_t;

  logic [CntW-1:0] managed_q;
  logic [CntW-1:0] reserved_q;
  logic            page_taken [NumPages];
  logic [CntW-1:0] run_len [NumPages];
  alloc_resp_t     resp_q[$];

  assign pending = resp_q.size();

  // Predict the response to one request and update the page tables.
  function automatic alloc_resp_t predict_request(logic fn, logic [CntW-1:0] cnt,
                                                  logic [PageW-1:0] addr);
    alloc_resp_t r;
    int lim;
    int run;
    int s;
    r.status = ST_INVALID;
    r.start_page = '0;
    lim = (managed_q < NumPages) ? managed_q : NumPages;
    if (fn == FUNC_ALLOC) begin
      if (cnt != 0) begin
        r.status = ST_NORUN;
        run = 0;
        for (int i = 0; i < lim; i++) begin
          run = (i >= reserved_q && !page_taken[i]) ? run + 1 : 0;
          if (run == cnt) begin
            s = i + 1 - cnt;
            for (int j = s; j <= i; j++) page_taken[j] = 1'b1;
            run_len[s] = cnt;
            r.status = ST_OK;
            r.start_page = s[PageW-1:0];
            break;
          end
        end
      end
    end else if (addr < lim && run_len[addr] != 0) begin
      for (int j = 0; j < run_len[addr] && addr + j < NumPages; j++)
        page_taken[addr + j] = 1'b0;
      run_len[addr] = '0;
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Track configuration, requests and responses.
  always @(posedge clk) begin
    alloc_resp_t want;
    alloc_resp_t got;
    if (rst) begin
      managed_q <= 11'd1024;
      reserved_q <= 11'd1;
      for (int i = 0; i < NumPages; i++) begin
        page_taken[i] = 1'b0;
        run_len[i] = '0;
      end
      resp_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MANAGED) managed_q <= cfg_data;
        else reserved_q <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready)
        resp_q.push_back(predict_request(s_axis_tuser, s_axis_tdata[10:0],
                                         s_axis_tdata[20:11]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tdata[1:0]);
        got.start_page = m_axis_tdata[11:2];
        if (resp_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected response %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_q.pop_front();
          if (got !== want || m_axis_tdata[15:12] !== 4'd0) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d page %0d, got status %0d page %0d",
                       want.status, want.start_page, m_axis_tdata[1:0], got.start_page);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/tb.sv
// Testbench top: drives requests and configuration into the page allocator.
module tb;
  import cpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [10:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          hold_rx;
  logic [PageW-1:0] live_blocks[$];

  contiguous_page_allocator_top dut (.*);
  cpa_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb NOT OK");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Response side: random back-pressure plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
  end

  task automatic send_request(logic fn, logic [CntW-1:0] cnt, logic [PageW-1:0] addr);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {3'd0, addr, cnt};
    @(posedge clk iff s_axis_tready);
    if (fn == FUNC_ALLOC) live_blocks.push_back(addr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of allocations, mostly of small sizes, and releases at random page addresses.
  task automatic random_phase(int n, int maxcnt);
    int k;
    logic [PageW-1:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50)
        send_request(FUNC_ALLOC, (k < 2) ? CntW'($urandom_range(0, 2047))
                                         : CntW'($urandom_range(1, maxcnt)),
                     PageW'($urandom));
      else if (k < 90) begin
        a = PageW'($urandom_range(0, 1023));
        send_request(FUNC_RELEASE, CntW'($urandom), a);
      end else
        send_request(FUNC_RELEASE, CntW'($urandom), PageW'($urandom));
    end
  endtask

  // Allocate and then release, taking the start page from the allocator's response.
  task automatic cycle_phase(int n, int maxcnt);
    int s;
    for (int i = 0; i < n; i++) begin
      send_request(FUNC_ALLOC, CntW'($urandom_range(1, maxcnt)), PageW'($urandom));
      drain_partial();
      if (chk_last_ok(s)) send_request(FUNC_RELEASE, CntW'($urandom), s[PageW-1:0]);
      else send_request(FUNC_RELEASE, CntW'($urandom), PageW'($urandom));
    end
  endtask

  task automatic drain_partial();
    @(posedge clk iff (m_axis_tvalid && m_axis_tready));
  endtask

  function automatic bit chk_last_ok(output int s);
    s = int'(m_axis_tdata[11:2]);
    return m_axis_tdata[1:0] == ST_OK;
  endfunction

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    hold_rx = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and each special case.
    send_request(FUNC_ALLOC, 11'd0, 10'd0);
    send_request(FUNC_ALLOC, 11'd1, 10'h3ff);
    send_request(FUNC_ALLOC, 11'd1024, 10'd0);
    send_request(FUNC_ALLOC, 11'd1023, 10'd0);
    send_request(FUNC_RELEASE, 11'h7ff, 10'd1);
    send_request(FUNC_ALLOC, 11'd1023, 10'd0);
    send_request(FUNC_RELEASE, 11'd0, 10'd5);
    send_request(FUNC_RELEASE, 11'd0, 10'd0);
    send_request(FUNC_RELEASE, 11'd0, 10'd1);
    send_request(FUNC_ALLOC, 11'h7ff, 10'd0);
    send_request(FUNC_ALLOC, 11'd4, 10'd0);
    send_request(FUNC_ALLOC, 11'd3, 10'd0);
    drain();
    write_reg(CFG_RESERVED, 11'd3);
    send_request(FUNC_RELEASE, 11'd0, 10'd1);
    send_request(FUNC_ALLOC, 11'd2, 10'd0);
    drain();
    write_reg(CFG_MANAGED, 11'd0);
    send_request(FUNC_ALLOC, 11'd1, 10'd0);
    send_request(FUNC_RELEASE, 11'd0, 10'd5);
    drain();
    write_reg(CFG_MANAGED, 11'h7ff);
    write_reg(CFG_RESERVED, 11'd0);
    send_request(FUNC_ALLOC, 11'd1, 10'd0);
    send_request(FUNC_RELEASE, 11'd0, 10'd0);
    drain();
    write_reg(CFG_RESERVED, 11'h7ff);
    send_request(FUNC_ALLOC, 11'd1, 10'd0);
    drain();

    // Random phases across settings.
    write_reg(CFG_MANAGED, 11'd64);
    write_reg(CFG_RESERVED, 11'd2);
    hold_rx = 1'b1;
    random_phase(300, 8);
    drain();
    cycle_phase(150, 16);
    drain();
    write_reg(CFG_MANAGED, 11'd1024);
    write_reg(CFG_RESERVED, 11'd1);
    random_phase(300, 40);
    drain();
    write_reg(CFG_MANAGED, 11'd1);
    write_reg(CFG_RESERVED, 11'd0);
    random_phase(60, 2);
    drain();
    write_reg(CFG_MANAGED, 11'd200);
    write_reg(CFG_RESERVED, 11'd17);
    random_phase(300, 12);
    drain();

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
